FILE: src/rceh_pkg.sv
package rceh_pkg;

    localparam int MAX_ENTRIES  = 1024;
    localparam int SLOT_W       = 10;
    localparam int LINK_W       = 11;
    localparam int KEY_BYTES    = 64;
    localparam int KEY_WORDS    = 8;
    localparam int WORD_W       = 3;
    localparam int BKT_W        = 8;
    localparam int BUCKET_COUNT = 256;
    localparam int KS_DEPTH     = MAX_ENTRIES * KEY_WORDS;
    localparam int LEN_W        = 7;
    localparam int CNT_W        = 4;

    localparam logic [LINK_W-1:0] NIL_SLOT  = 11'd1024;
    localparam logic [31:0]       FNV_BASIS = 32'd2166136261;
    localparam logic [31:0]       FNV_PRIME = 32'd16777619;

    localparam logic [1:0] OP_TAKE    = 2'd0;
    localparam logic [1:0] OP_DROP    = 2'd1;
    localparam logic [1:0] OP_CAPTURE = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    localparam logic [2:0] ST_TRACKED   = 3'd0;
    localparam logic [2:0] ST_UNTRACKED = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_DROP_ERR  = 3'd3;
    localparam logic [2:0] ST_ENTRY     = 3'd4;
    localparam logic [2:0] ST_CAP_DONE  = 3'd5;
    localparam logic [2:0] ST_REFUSED   = 3'd6;
    localparam logic [2:0] ST_KEY       = 3'd7;

    localparam int UOP_W = 6;
    localparam logic [UOP_W-1:0] U_CLEAR    = 6'd0;
    localparam logic [UOP_W-1:0] U_IDLE     = 6'd1;
    localparam logic [UOP_W-1:0] U_ABSORB   = 6'd2;
    localparam logic [UOP_W-1:0] U_FIN      = 6'd3;
    localparam logic [UOP_W-1:0] U_UNTR     = 6'd4;
    localparam logic [UOP_W-1:0] U_BH_RD    = 6'd5;
    localparam logic [UOP_W-1:0] U_BH_GOT   = 6'd6;
    localparam logic [UOP_W-1:0] U_WALK     = 6'd7;
    localparam logic [UOP_W-1:0] U_CMP_RD   = 6'd8;
    localparam logic [UOP_W-1:0] U_CMP_CHK  = 6'd9;
    localparam logic [UOP_W-1:0] U_CMP_END  = 6'd10;
    localparam logic [UOP_W-1:0] U_LINK_RD  = 6'd11;
    localparam logic [UOP_W-1:0] U_LINK_GOT = 6'd12;
    localparam logic [UOP_W-1:0] U_NEW      = 6'd13;
    localparam logic [UOP_W-1:0] U_NEW2     = 6'd14;
    localparam logic [UOP_W-1:0] U_STORE    = 6'd15;
    localparam logic [UOP_W-1:0] U_NEWCNT   = 6'd16;
    localparam logic [UOP_W-1:0] U_RC_RD    = 6'd17;
    localparam logic [UOP_W-1:0] U_RC_INC   = 6'd18;
    localparam logic [UOP_W-1:0] U_DROPU    = 6'd19;
    localparam logic [UOP_W-1:0] U_DROP_RD  = 6'd20;
    localparam logic [UOP_W-1:0] U_DROP_CHK = 6'd21;
    localparam logic [UOP_W-1:0] U_UNL_RD   = 6'd22;
    localparam logic [UOP_W-1:0] U_UNL_GOT  = 6'd23;
    localparam logic [UOP_W-1:0] U_UNL_BH   = 6'd24;
    localparam logic [UOP_W-1:0] U_UNL_BH2  = 6'd25;
    localparam logic [UOP_W-1:0] U_UNL_WALK = 6'd26;
    localparam logic [UOP_W-1:0] U_UNL_CHK  = 6'd27;
    localparam logic [UOP_W-1:0] U_FREE     = 6'd28;
    localparam logic [UOP_W-1:0] U_CAP      = 6'd29;
    localparam logic [UOP_W-1:0] U_CAP_HEAD = 6'd30;
    localparam logic [UOP_W-1:0] U_CAP_SCAN = 6'd31;
    localparam logic [UOP_W-1:0] U_CAP_GOT  = 6'd32;
    localparam logic [UOP_W-1:0] U_KRD      = 6'd33;
    localparam logic [UOP_W-1:0] U_KGOT     = 6'd34;
    localparam logic [UOP_W-1:0] U_EMIT     = 6'd35;

    typedef struct packed {
        logic [UOP_W-1:0] uop;
        logic             load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic byte_last;
        logic chunk_last;
        logic enabled;
        logic key_valid;
        logic too_long;
        logic cur_nil;
        logic word_last;
        logic mism;
        logic free_nil;
        logic untr_zero;
        logic rc_zero;
        logic rc_one;
        logic head_is_s;
        logic link_is_s;
        logic cap_active;
        logic cap_nil;
        logic bucket_last;
        logic out_free;
    } sts_t;

endpackage

FILE: src/rceh_if.sv
interface rceh_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] key_chunk;
    logic        chunk_last;
    logic        key_valid;
    logic        enabled;
    logic [9:0]  slot;
    logic        drop_untracked;
    logic [2:0]  chunk_index;

    modport source (output valid, op, key_chunk, chunk_last, key_valid, enabled, slot,
                    drop_untracked, chunk_index, input ready);
    modport sink (input valid, op, key_chunk, chunk_last, key_valid, enabled, slot,
                  drop_untracked, chunk_index, output ready);
endinterface

interface rceh_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  slot_out;
    logic [31:0] count;
    logic [63:0] key_data;

    modport source (output valid, status, slot_out, count, key_data, input ready);
    modport sink (input valid, status, slot_out, count, key_data, output ready);
endinterface

FILE: src/refcounted_endpoint_hash_table.sv
// Channel  Role    Payload
// req      sink    op, key_chunk, chunk_last, key_valid, enabled, slot,
//                  drop_untracked, chunk_index
// rsp      source  status, slot_out, count, key_data
//
// After reset a clear pass initializes counts, links and bucket heads;
// req.ready stays low until it ends.
// A take chunk hashes one byte per cycle; the final chunk adds a chain walk
// that compares 8 key words per entry through the key memory port, plus a
// store of the 8 key words for a new entry.
// A drop that frees an entry walks the entries ahead of it in its chain; a
// capture step scans past empty buckets.
// A result waits in the rsp register; the next item is taken while it stalls.
module refcounted_endpoint_hash_table
    import rceh_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    rceh_req_if.sink    req,
    rceh_rsp_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;
    logic ready;

    assign req.ready = ready;

    rceh_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (req.valid),
        .in_op             (req.op),
        .in_drop_untracked (req.drop_untracked),
        .in_ready          (ready),
        .sts               (sts),
        .cmd               (cmd)
    );

    rceh_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_key_chunk   (req.key_chunk),
        .in_chunk_last  (req.chunk_last),
        .in_key_valid   (req.key_valid),
        .in_enabled     (req.enabled),
        .in_slot        (req.slot),
        .in_chunk_index (req.chunk_index),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_status     (rsp.status),
        .out_slot       (rsp.slot_out),
        .out_count      (rsp.count),
        .out_key_data   (rsp.key_data)
    );

endmodule

FILE: src/rceh_ctrl.sv
module rceh_ctrl
    import rceh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    input  logic       in_drop_untracked,
    output logic       in_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    logic [UOP_W-1:0] state_reg;
    logic [UOP_W-1:0] state_next;

    assign in_ready = (state_reg == U_IDLE);
    assign cmd.uop  = state_reg;
    assign cmd.load = in_ready && in_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_CLEAR:    if (sts.clr_done) state_next = U_IDLE;
            U_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_TAKE:    state_next = U_ABSORB;
                        OP_DROP:    state_next = in_drop_untracked ? U_DROPU : U_DROP_RD;
                        OP_CAPTURE: state_next = U_CAP;
                        OP_READ:    state_next = U_KRD;
                        default:    state_next = U_IDLE;
                    endcase
                end
            end
            U_ABSORB:
            begin
                if (sts.byte_last)
                    state_next = sts.chunk_last ? U_FIN : U_IDLE;
            end
            U_FIN:
            begin
                priority if (!sts.enabled)                   state_next = U_IDLE;
                else if (!sts.key_valid || sts.too_long)     state_next = U_UNTR;
                else                                         state_next = U_BH_RD;
            end
            U_UNTR:     state_next = U_EMIT;
            U_BH_RD:    state_next = U_BH_GOT;
            U_BH_GOT:   state_next = U_WALK;
            U_WALK:     state_next = sts.cur_nil ? U_NEW : U_CMP_RD;
            U_CMP_RD:   state_next = U_CMP_CHK;
            U_CMP_CHK:  state_next = sts.word_last ? U_CMP_END : U_CMP_RD;
            U_CMP_END:  state_next = sts.mism ? U_LINK_RD : U_RC_RD;
            U_LINK_RD:  state_next = U_LINK_GOT;
            U_LINK_GOT: state_next = U_WALK;
            U_NEW:      state_next = sts.free_nil ? U_UNTR : U_NEW2;
            U_NEW2:     state_next = U_STORE;
            U_STORE:    if (sts.word_last) state_next = U_NEWCNT;
            U_NEWCNT:   state_next = U_EMIT;
            U_RC_RD:    state_next = U_RC_INC;
            U_RC_INC:   state_next = U_EMIT;
            U_DROPU:    state_next = U_EMIT;
            U_DROP_RD:  state_next = U_DROP_CHK;
            U_DROP_CHK: state_next = (!sts.rc_zero && sts.rc_one) ? U_UNL_RD : U_EMIT;
            U_UNL_RD:   state_next = U_UNL_GOT;
            U_UNL_GOT:  state_next = U_UNL_BH;
            U_UNL_BH:   state_next = U_UNL_BH2;
            U_UNL_BH2:  state_next = sts.head_is_s ? U_FREE : U_UNL_WALK;
            U_UNL_WALK: state_next = sts.cur_nil ? U_FREE : U_UNL_CHK;
            U_UNL_CHK:  state_next = sts.link_is_s ? U_FREE : U_UNL_WALK;
            U_FREE:     state_next = U_EMIT;
            U_CAP:
            begin
                priority if (!sts.untr_zero) state_next = U_EMIT;
                else if (!sts.cap_active)    state_next = U_CAP_HEAD;
                else                         state_next = U_CAP_SCAN;
            end
            U_CAP_HEAD: state_next = U_CAP_SCAN;
            U_CAP_SCAN:
            begin
                priority if (sts.cap_nil && !sts.bucket_last) state_next = U_CAP_HEAD;
                else if (sts.cap_nil)                         state_next = U_EMIT;
                else                                          state_next = U_CAP_GOT;
            end
            U_CAP_GOT:  state_next = U_EMIT;
            U_KRD:      state_next = U_KGOT;
            U_KGOT:     state_next = U_EMIT;
            U_EMIT:     if (sts.out_free) state_next = U_IDLE;
            default:    state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= U_CLEAR;
        else
            state_reg <= state_next;
    end

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != U_CLEAR |=> state_reg != U_CLEAR)
        else $error("table clear pass restarted");

    a_take_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == U_ABSORB && !sts.byte_last |=> state_reg == U_ABSORB)
        else $error("byte hashing left early");

endmodule

FILE: src/rceh_dp.sv
module rceh_dp
    import rceh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [63:0] in_key_chunk,
    input  logic        in_chunk_last,
    input  logic        in_key_valid,
    input  logic        in_enabled,
    input  logic [9:0]  in_slot,
    input  logic [2:0]  in_chunk_index,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  out_status,
    output logic [9:0]  out_slot,
    output logic [31:0] out_count,
    output logic [63:0] out_key_data
);

    logic [63:0]       ks_mem [KS_DEPTH];
    logic [31:0]       rc_mem [MAX_ENTRIES];
    logic [LINK_W-1:0] cl_mem [MAX_ENTRIES];
    logic [BKT_W-1:0]  hb_mem [MAX_ENTRIES];
    logic [LINK_W-1:0] bh_mem [BUCKET_COUNT];
    logic [63:0]       kbuf_reg [KEY_WORDS];

    logic [63:0]       ks_q;
    logic [31:0]       rc_q;
    logic [LINK_W-1:0] cl_q;
    logic [BKT_W-1:0]  hb_q;
    logic [LINK_W-1:0] bh_q;

    logic                      ks_we, rc_we, cl_we, hb_we, bh_we, kbuf_we;
    logic [SLOT_W+WORD_W-1:0]  ks_wa, ks_ra;
    logic [63:0]               ks_wd;
    logic [SLOT_W-1:0]         rc_wa, rc_ra, cl_wa, cl_ra, hb_wa, hb_ra;
    logic [31:0]               rc_wd;
    logic [LINK_W-1:0]         cl_wd, bh_wd;
    logic [BKT_W-1:0]          hb_wd, bh_wa, bh_ra;
    logic [WORD_W-1:0]         kbuf_wa;
    logic [63:0]               kbuf_wd;

    logic [31:0]       hash_reg, hash_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ended_reg, ended_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LINK_W-1:0] free_reg, free_next;
    logic [31:0]       untr_reg, untr_next;
    logic [BKT_W-1:0]  capb_reg, capb_next;
    logic [LINK_W-1:0] capc_reg, capc_next;
    logic              capa_reg, capa_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic              ov_reg, ov_next;

    logic [63:0]       chunk_reg, chunk_next;
    logic [63:0]       kept_reg, kept_next;
    logic [WORD_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              kv_reg, kv_next;
    logic              en_reg, en_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WORD_W-1:0] ci_reg, ci_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] lnk_reg, lnk_next;
    logic [BKT_W-1:0]  bkt_reg, bkt_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              mism_reg, mism_next;
    logic [CNT_W-1:0]  ncnt_reg, ncnt_next;
    logic [2:0]        rs_reg, rs_next;
    logic [SLOT_W-1:0] rsl_reg, rsl_next;
    logic [31:0]       rc_reg, rcn_next;
    logic [63:0]       rd_reg, rd_next;
    logic [2:0]        os_reg, os_next;
    logic [SLOT_W-1:0] osl_reg, osl_next;
    logic [31:0]       oc_reg, oc_next;
    logic [63:0]       od_reg, od_next;

    logic [7:0]        byte_v;
    logic [31:0]       hmul;
    logic [63:0]       buf_word;
    logic [31:0]       rc_dec;
    logic [LINK_W-1:0] slot_ext;

    assign byte_v   = chunk_reg[{byte_reg, 3'b000} +: 8];
    assign hmul     = (hash_reg ^ {24'd0, byte_v}) * FNV_PRIME;
    assign buf_word = ({1'b0, word_reg} < ncnt_reg) ? kbuf_reg[word_reg] : 64'd0;
    assign rc_dec   = rc_q - 32'd1;
    assign slot_ext = {1'b0, slot_reg};

    assign sts.clr_done    = (clr_reg == {SLOT_W{1'b1}});
    assign sts.byte_last   = (byte_reg == {WORD_W{1'b1}});
    assign sts.chunk_last  = last_reg;
    assign sts.enabled     = en_reg;
    assign sts.key_valid   = kv_reg;
    assign sts.too_long    = (len_reg == LEN_W'(KEY_BYTES));
    assign sts.cur_nil     = cur_reg[LINK_W-1];
    assign sts.word_last   = (word_reg == {WORD_W{1'b1}});
    assign sts.mism        = mism_reg;
    assign sts.free_nil    = free_reg[LINK_W-1];
    assign sts.untr_zero   = (untr_reg == 32'd0);
    assign sts.rc_zero     = (rc_q == 32'd0);
    assign sts.rc_one      = (rc_q == 32'd1);
    assign sts.head_is_s   = (bh_q == slot_ext);
    assign sts.link_is_s   = (cl_q == slot_ext);
    assign sts.cap_active  = capa_reg;
    assign sts.cap_nil     = capc_reg[LINK_W-1];
    assign sts.bucket_last = (capb_reg == {BKT_W{1'b1}});
    assign sts.out_free    = !ov_reg || out_ready;

    assign out_valid    = ov_reg;
    assign out_status   = os_reg;
    assign out_slot     = osl_reg;
    assign out_count    = oc_reg;
    assign out_key_data = od_reg;

    always_comb
    begin
        hash_next = hash_reg;  len_next = len_reg;    ended_next = ended_reg;
        cnt_next = cnt_reg;    free_next = free_reg;  untr_next = untr_reg;
        capb_next = capb_reg;  capc_next = capc_reg;  capa_next = capa_reg;
        clr_next = clr_reg;    ov_next = ov_reg;
        chunk_next = chunk_reg; kept_next = kept_reg; byte_next = byte_reg;
        last_next = last_reg;  kv_next = kv_reg;      en_next = en_reg;
        slot_next = slot_reg;  ci_next = ci_reg;      cur_next = cur_reg;
        head_next = head_reg;  lnk_next = lnk_reg;    bkt_next = bkt_reg;
        word_next = word_reg;  mism_next = mism_reg;  ncnt_next = ncnt_reg;
        rs_next = rs_reg;      rsl_next = rsl_reg;    rcn_next = rc_reg;
        rd_next = rd_reg;
        os_next = os_reg;      osl_next = osl_reg;    oc_next = oc_reg;
        od_next = od_reg;

        ks_we = 1'b0; ks_wa = {cur_reg[SLOT_W-1:0], word_reg}; ks_wd = buf_word;
        ks_ra = {cur_reg[SLOT_W-1:0], word_reg};
        rc_we = 1'b0; rc_wa = cur_reg[SLOT_W-1:0]; rc_wd = 32'd0; rc_ra = cur_reg[SLOT_W-1:0];
        cl_we = 1'b0; cl_wa = cur_reg[SLOT_W-1:0]; cl_wd = lnk_reg; cl_ra = cur_reg[SLOT_W-1:0];
        hb_we = 1'b0; hb_wa = cur_reg[SLOT_W-1:0]; hb_wd = bkt_reg; hb_ra = slot_reg;
        bh_we = 1'b0; bh_wa = bkt_reg; bh_wd = lnk_reg; bh_ra = bkt_reg;
        kbuf_we = 1'b0; kbuf_wa = cnt_reg[WORD_W-1:0]; kbuf_wd = kept_reg;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (cmd.uop)
            U_CLEAR:
            begin
                rc_we = 1'b1; rc_wa = clr_reg; rc_wd = 32'd0;
                cl_we = 1'b1; cl_wa = clr_reg;
                cl_wd = (clr_reg == '0) ? NIL_SLOT : {1'b0, clr_reg - 10'd1};
                bh_we = 1'b1; bh_wa = clr_reg[BKT_W-1:0]; bh_wd = NIL_SLOT;
                clr_next = clr_reg + 10'd1;
            end
            U_IDLE:
            begin
                if (cmd.load)
                begin
                    chunk_next = in_key_chunk;
                    kept_next  = 64'd0;
                    byte_next  = '0;
                    last_next  = in_chunk_last;
                    kv_next    = in_key_valid;
                    en_next    = in_enabled;
                    slot_next  = in_slot;
                    ci_next    = in_chunk_index;
                end
            end
            U_ABSORB:
            begin
                if (ended_reg || byte_v == 8'd0)
                    ended_next = 1'b1;
                else
                begin
                    kept_next = kept_reg | ({56'd0, byte_v} << {byte_reg, 3'b000});
                    hash_next = hmul;
                    if (len_reg != LEN_W'(KEY_BYTES))
                        len_next = len_reg + 7'd1;
                end
                byte_next = byte_reg + 3'd1;
                if (byte_reg == {WORD_W{1'b1}} && cnt_reg != CNT_W'(KEY_WORDS))
                begin
                    kbuf_we  = 1'b1;
                    kbuf_wd  = kept_next;
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            U_FIN:
            begin
                bkt_next   = hash_reg[BKT_W-1:0];
                ncnt_next  = cnt_reg;
                hash_next  = FNV_BASIS;
                len_next   = '0;
                ended_next = 1'b0;
                cnt_next   = '0;
            end
            U_UNTR:
            begin
                if (untr_reg != 32'hFFFF_FFFF)
                    untr_next = untr_reg + 32'd1;
                rs_next = ST_UNTRACKED; rsl_next = '0; rcn_next = '0; rd_next = '0;
            end
            U_BH_RD:    bh_ra = bkt_reg;
            U_BH_GOT:
            begin
                cur_next  = bh_q;
                head_next = bh_q;
            end
            U_WALK:
            begin
                word_next = '0;
                mism_next = 1'b0;
            end
            U_CMP_RD:   ks_ra = {cur_reg[SLOT_W-1:0], word_reg};
            U_CMP_CHK:
            begin
                if (ks_q != buf_word)
                    mism_next = 1'b1;
                word_next = word_reg + 3'd1;
            end
            U_CMP_END:  ;
            U_LINK_RD:  cl_ra = cur_reg[SLOT_W-1:0];
            U_LINK_GOT: cur_next = cl_q;
            U_NEW:
            begin
                cur_next = free_reg;
                cl_ra    = free_reg[SLOT_W-1:0];
            end
            U_NEW2:
            begin
                free_next = cl_q;
                cl_we = 1'b1; cl_wa = cur_reg[SLOT_W-1:0]; cl_wd = head_reg;
                hb_we = 1'b1; hb_wa = cur_reg[SLOT_W-1:0]; hb_wd = bkt_reg;
                bh_we = 1'b1; bh_wa = bkt_reg; bh_wd = cur_reg;
                word_next = '0;
            end
            U_STORE:
            begin
                ks_we = 1'b1;
                word_next = word_reg + 3'd1;
            end
            U_NEWCNT:
            begin
                rc_we = 1'b1; rc_wa = cur_reg[SLOT_W-1:0]; rc_wd = 32'd1;
                rs_next = ST_TRACKED; rsl_next = cur_reg[SLOT_W-1:0];
                rcn_next = 32'd1; rd_next = '0;
            end
            U_RC_RD:    rc_ra = cur_reg[SLOT_W-1:0];
            U_RC_INC:
            begin
                rc_we = 1'b1; rc_wa = cur_reg[SLOT_W-1:0];
                rc_wd = (rc_q == 32'hFFFF_FFFF) ? rc_q : rc_q + 32'd1;
                rs_next = ST_TRACKED; rsl_next = cur_reg[SLOT_W-1:0];
                rcn_next = rc_wd; rd_next = '0;
            end
            U_DROPU:
            begin
                rsl_next = '0; rcn_next = '0; rd_next = '0;
                if (untr_reg == 32'd0)
                    rs_next = ST_DROP_ERR;
                else
                begin
                    untr_next = untr_reg - 32'd1;
                    rs_next   = ST_DROPPED;
                end
            end
            U_DROP_RD:  rc_ra = slot_reg;
            U_DROP_CHK:
            begin
                rsl_next = slot_reg; rd_next = '0;
                if (rc_q == 32'd0)
                begin
                    rs_next = ST_DROP_ERR; rcn_next = '0;
                end
                else
                begin
                    rc_we = 1'b1; rc_wa = slot_reg; rc_wd = rc_dec;
                    rs_next = ST_DROPPED; rcn_next = rc_dec;
                end
            end
            U_UNL_RD:
            begin
                cl_ra = slot_reg;
                hb_ra = slot_reg;
            end
            U_UNL_GOT:
            begin
                lnk_next = cl_q;
                bkt_next = hb_q;
                if (capa_reg && capc_reg == slot_ext)
                    capc_next = cl_q;
            end
            U_UNL_BH:   bh_ra = bkt_reg;
            U_UNL_BH2:
            begin
                if (bh_q == slot_ext)
                begin
                    bh_we = 1'b1; bh_wa = bkt_reg; bh_wd = lnk_reg;
                end
                else
                    cur_next = bh_q;
            end
            U_UNL_WALK: cl_ra = cur_reg[SLOT_W-1:0];
            U_UNL_CHK:
            begin
                if (cl_q == slot_ext)
                begin
                    cl_we = 1'b1; cl_wa = cur_reg[SLOT_W-1:0]; cl_wd = lnk_reg;
                end
                else
                    cur_next = cl_q;
            end
            U_FREE:
            begin
                cl_we = 1'b1; cl_wa = slot_reg; cl_wd = free_reg;
                free_next = slot_ext;
                rs_next = ST_DROPPED; rsl_next = slot_reg; rcn_next = '0; rd_next = '0;
            end
            U_CAP:
            begin
                rsl_next = '0; rcn_next = '0; rd_next = '0; rs_next = ST_REFUSED;
                if (untr_reg != 32'd0)
                    capa_next = 1'b0;
                else if (!capa_reg)
                begin
                    capa_next = 1'b1;
                    capb_next = '0;
                    bh_ra     = '0;
                end
            end
            U_CAP_HEAD: capc_next = bh_q;
            U_CAP_SCAN:
            begin
                rsl_next = '0; rcn_next = '0; rd_next = '0;
                if (capc_reg[LINK_W-1] && capb_reg != {BKT_W{1'b1}})
                begin
                    capb_next = capb_reg + 8'd1;
                    bh_ra     = capb_reg + 8'd1;
                end
                else if (capc_reg[LINK_W-1])
                begin
                    capa_next = 1'b0;
                    capb_next = '0;
                    capc_next = NIL_SLOT;
                    rs_next   = ST_CAP_DONE;
                end
                else
                begin
                    cl_ra = capc_reg[SLOT_W-1:0];
                    rc_ra = capc_reg[SLOT_W-1:0];
                end
            end
            U_CAP_GOT:
            begin
                rs_next = ST_ENTRY; rsl_next = capc_reg[SLOT_W-1:0];
                rcn_next = rc_q; rd_next = '0;
                capc_next = cl_q;
            end
            U_KRD:      ks_ra = {slot_reg, ci_reg};
            U_KGOT:
            begin
                rs_next = ST_KEY; rsl_next = slot_reg; rcn_next = '0; rd_next = ks_q;
            end
            U_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next  = 1'b1;
                    os_next  = rs_reg;
                    osl_next = rsl_reg;
                    oc_next  = rc_reg;
                    od_next  = rd_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ks_we)
            ks_mem[ks_wa] <= ks_wd;
        ks_q <= ks_mem[ks_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rc_we)
            rc_mem[rc_wa] <= rc_wd;
        rc_q <= rc_mem[rc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cl_we)
            cl_mem[cl_wa] <= cl_wd;
        cl_q <= cl_mem[cl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (hb_we)
            hb_mem[hb_wa] <= hb_wd;
        hb_q <= hb_mem[hb_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bh_we)
            bh_mem[bh_wa] <= bh_wd;
        bh_q <= bh_mem[bh_ra];
    end

    always_ff @(posedge clk)
    begin
        if (kbuf_we)
            kbuf_reg[kbuf_wa] <= kbuf_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= FNV_BASIS;
            len_reg   <= '0;
            ended_reg <= 1'b0;
            cnt_reg   <= '0;
            free_reg  <= LINK_W'(MAX_ENTRIES - 1);
            untr_reg  <= '0;
            capb_reg  <= '0;
            capc_reg  <= NIL_SLOT;
            capa_reg  <= 1'b0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            hash_reg  <= hash_next;
            len_reg   <= len_next;
            ended_reg <= ended_next;
            cnt_reg   <= cnt_next;
            free_reg  <= free_next;
            untr_reg  <= untr_next;
            capb_reg  <= capb_next;
            capc_reg  <= capc_next;
            capa_reg  <= capa_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chunk_reg <= chunk_next; kept_reg <= kept_next; byte_reg <= byte_next;
        last_reg  <= last_next;  kv_reg   <= kv_next;   en_reg   <= en_next;
        slot_reg  <= slot_next;  ci_reg   <= ci_next;   cur_reg  <= cur_next;
        head_reg  <= head_next;  lnk_reg  <= lnk_next;  bkt_reg  <= bkt_next;
        word_reg  <= word_next;  mism_reg <= mism_next; ncnt_reg <= ncnt_next;
        rs_reg    <= rs_next;    rsl_reg  <= rsl_next;  rc_reg   <= rcn_next;
        rd_reg    <= rd_next;
        os_reg    <= os_next;    osl_reg  <= osl_next;  oc_reg   <= oc_next;
        od_reg    <= od_next;
    end

    a_free_nil_form: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg[LINK_W-1] |-> free_reg[SLOT_W-1:0] == '0)
        else $error("free list head out of range");

    a_cursor_nil_form: assert property (@(posedge clk) disable iff (!rst_n)
        capc_reg[LINK_W-1] |-> capc_reg[SLOT_W-1:0] == '0)
        else $error("capture cursor out of range");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.uop == U_EMIT && sts.out_free |=> ov_reg)
        else $error("result not presented after emit");

endmodule

FILE: bench/tb_refcounted_endpoint_hash_table.sv
module tb_refcounted_endpoint_hash_table;
    import rceh_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key_chunk;
        logic        chunk_last;
        logic        key_valid;
        logic        enabled;
        logic [9:0]  slot;
        logic        drop_untracked;
        logic [2:0]  chunk_index;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot_out;
        logic [31:0] count;
        logic [63:0] key_data;
    } rsp_item_t;

    logic clk;
    logic rst_n;

    rceh_req_if req ();
    rceh_rsp_if rsp ();

    refcounted_endpoint_hash_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // table shadow
    logic [63:0]       tbl_key [KS_DEPTH];
    logic              tbl_written [MAX_ENTRIES];
    logic [31:0]       tbl_count [MAX_ENTRIES];
    logic [LINK_W-1:0] tbl_link [MAX_ENTRIES];
    logic [BKT_W-1:0]  tbl_home [MAX_ENTRIES];
    logic [LINK_W-1:0] tbl_head [BUCKET_COUNT];
    logic [LINK_W-1:0] tbl_free;
    logic [31:0]       tbl_untracked;
    logic [63:0]       tk_buf [KEY_WORDS];
    int                tk_chunks;
    int                tk_len;
    bit                tk_ended;
    logic [31:0]       tk_hash;
    int                cap_bucket;
    logic [LINK_W-1:0] cap_cursor;
    bit                cap_active;

    rsp_item_t   awaited_results[$];
    req_item_t   pend[$];
    logic [9:0]  taken_slots[$];
    logic [9:0]  written_slots[$];

    req_item_t cur_item;
    int        n_queued;
    int        n_accepted;
    int        send_gap;
    int        recv_gap;
    int        recv_hold;
    int        recv_cycles;
    int        cyc;
    int        errors;
    bit        calm;

    function automatic void clear_take_state();
        for (int w = 0; w < KEY_WORDS; w++)
            tk_buf[w] = '0;
        tk_chunks = 0;
        tk_len = 0;
        tk_ended = 1'b0;
        tk_hash = FNV_BASIS;
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            tbl_count[i] = '0;
            tbl_written[i] = 1'b0;
            tbl_home[i] = '0;
            tbl_link[i] = (i == 0) ? NIL_SLOT : LINK_W'(i - 1);
        end
        for (int b = 0; b < BUCKET_COUNT; b++)
            tbl_head[b] = NIL_SLOT;
        tbl_free = LINK_W'(MAX_ENTRIES - 1);
        tbl_untracked = '0;
        clear_take_state();
        cap_bucket = 0;
        cap_cursor = NIL_SLOT;
        cap_active = 1'b0;
    endfunction

    function automatic void expect_result(logic [2:0] st, logic [9:0] s, logic [31:0] c,
                                          logic [63:0] d);
        rsp_item_t r;
        r.status = st;
        r.slot_out = s;
        r.count = c;
        r.key_data = d;
        awaited_results.push_back(r);
    endfunction

    function automatic void mark_untracked();
        if (tbl_untracked != 32'hFFFF_FFFF)
            tbl_untracked++;
        expect_result(ST_UNTRACKED, '0, '0, '0);
    endfunction

    function automatic void absorb_chunk(logic [63:0] chunk);
        logic [63:0] kept;
        logic [7:0]  byt;
        kept = '0;
        for (int b = 0; b < 8; b++)
        begin
            byt = chunk[8*b +: 8];
            if (tk_ended || byt == 8'd0)
                tk_ended = 1'b1;
            else
            begin
                kept[8*b +: 8] = byt;
                tk_hash = (tk_hash ^ {24'd0, byt}) * FNV_PRIME;
                if (tk_len < KEY_BYTES)
                    tk_len++;
            end
        end
        if (tk_chunks < KEY_WORDS)
        begin
            tk_buf[tk_chunks] = kept;
            tk_chunks++;
        end
    endfunction

    function automatic void finish_take(req_item_t it);
        logic [BKT_W-1:0]  bkt;
        logic [LINK_W-1:0] i;
        bit                same;
        bkt = tk_hash[BKT_W-1:0];
        if (!it.enabled)
            return;
        if (!it.key_valid || tk_len >= KEY_BYTES)
        begin
            mark_untracked();
            return;
        end
        i = tbl_head[bkt];
        while (i != NIL_SLOT)
        begin
            same = 1'b1;
            for (int w = 0; w < KEY_WORDS; w++)
                if (tbl_key[i*KEY_WORDS + w] != tk_buf[w])
                    same = 1'b0;
            if (same)
                break;
            i = tbl_link[i];
        end
        if (i == NIL_SLOT)
        begin
            i = tbl_free;
            if (i == NIL_SLOT)
            begin
                mark_untracked();
                return;
            end
            tbl_free = tbl_link[i];
            tbl_link[i] = tbl_head[bkt];
            tbl_head[bkt] = i;
            tbl_home[i] = bkt;
            tbl_count[i] = '0;
            for (int w = 0; w < KEY_WORDS; w++)
                tbl_key[i*KEY_WORDS + w] = tk_buf[w];
            if (!tbl_written[i])
                written_slots.push_back(i[9:0]);
            tbl_written[i] = 1'b1;
        end
        if (tbl_count[i] != 32'hFFFF_FFFF)
            tbl_count[i]++;
        taken_slots.push_back(i[9:0]);
        expect_result(ST_TRACKED, i[9:0], tbl_count[i], '0);
    endfunction

    function automatic void drop_entry(req_item_t it);
        logic [9:0]        s;
        logic [LINK_W-1:0] p;
        logic [BKT_W-1:0]  b;
        s = it.slot;
        if (it.drop_untracked)
        begin
            if (tbl_untracked == 0)
                expect_result(ST_DROP_ERR, '0, '0, '0);
            else
            begin
                tbl_untracked--;
                expect_result(ST_DROPPED, '0, '0, '0);
            end
            return;
        end
        if (tbl_count[s] == 0)
        begin
            expect_result(ST_DROP_ERR, s, '0, '0);
            return;
        end
        tbl_count[s]--;
        if (tbl_count[s] != 0)
        begin
            expect_result(ST_DROPPED, s, tbl_count[s], '0);
            return;
        end
        if (cap_active && cap_cursor == {1'b0, s})
            cap_cursor = tbl_link[s];
        b = tbl_home[s];
        if (tbl_head[b] == {1'b0, s})
            tbl_head[b] = tbl_link[s];
        else
        begin
            p = tbl_head[b];
            while (p != NIL_SLOT)
            begin
                if (tbl_link[p] == {1'b0, s})
                begin
                    tbl_link[p] = tbl_link[s];
                    break;
                end
                p = tbl_link[p];
            end
        end
        tbl_link[s] = tbl_free;
        tbl_free = {1'b0, s};
        expect_result(ST_DROPPED, s, '0, '0);
    endfunction

    function automatic void capture_step();
        logic [LINK_W-1:0] e;
        if (tbl_untracked != 0)
        begin
            cap_active = 1'b0;
            expect_result(ST_REFUSED, '0, '0, '0);
            return;
        end
        if (!cap_active)
        begin
            cap_active = 1'b1;
            cap_bucket = 0;
            cap_cursor = tbl_head[0];
        end
        while (cap_cursor == NIL_SLOT && cap_bucket + 1 < BUCKET_COUNT)
        begin
            cap_bucket++;
            cap_cursor = tbl_head[cap_bucket];
        end
        if (cap_cursor == NIL_SLOT)
        begin
            cap_active = 1'b0;
            cap_bucket = 0;
            expect_result(ST_CAP_DONE, '0, '0, '0);
            return;
        end
        e = cap_cursor;
        cap_cursor = tbl_link[e];
        expect_result(ST_ENTRY, e[9:0], tbl_count[e], '0);
    endfunction

    function automatic void apply_transfer(req_item_t it);
        case (it.op)
            OP_TAKE:
            begin
                absorb_chunk(it.key_chunk);
                if (it.chunk_last)
                begin
                    finish_take(it);
                    clear_take_state();
                end
            end
            OP_DROP:    drop_entry(it);
            OP_CAPTURE: capture_step();
            default:
                expect_result(ST_KEY, it.slot, '0,
                              tbl_written[it.slot] ?
                              tbl_key[it.slot*KEY_WORDS + it.chunk_index] : 64'd0);
        endcase
    endfunction

    // stimulus helpers
    function automatic req_item_t noise_item();
        req_item_t it;
        it.op = 2'($urandom_range(0, 3));
        it.key_chunk = {$urandom, $urandom};
        it.chunk_last = 1'($urandom);
        it.key_valid = 1'($urandom);
        it.enabled = 1'($urandom);
        it.slot = 10'($urandom);
        it.drop_untracked = 1'($urandom);
        it.chunk_index = 3'($urandom);
        return it;
    endfunction

    function automatic void push_item(req_item_t it);
        pend.push_back(it);
        n_queued++;
    endfunction

    function automatic void queue_take(byte unsigned kb[$], bit open_end, int extra,
                                       bit kv, bit en);
        req_item_t it;
        int n;
        int nch;
        int p;
        n = kb.size();
        nch = (open_end && n > 0 && n % 8 == 0) ? n / 8 : n / 8 + 1;
        nch += extra;
        for (int c = 0; c < nch; c++)
        begin
            it = noise_item();
            it.op = OP_TAKE;
            for (int b = 0; b < 8; b++)
            begin
                p = c * 8 + b;
                if (p < n)
                    it.key_chunk[8*b +: 8] = kb[p];
                else if (p == n && !open_end)
                    it.key_chunk[8*b +: 8] = 8'd0;
            end
            it.chunk_last = (c == nch - 1);
            if (c == nch - 1)
            begin
                it.key_valid = kv;
                it.enabled = en;
            end
            push_item(it);
        end
    endfunction

    function automatic void queue_simple(logic [1:0] op, logic [9:0] s, bit untr,
                                         logic [2:0] ci);
        req_item_t it;
        it = noise_item();
        it.op = op;
        it.slot = s;
        it.drop_untracked = untr;
        it.chunk_index = ci;
        push_item(it);
    endfunction

    function automatic void make_key(int n, output byte unsigned kb[$]);
        kb = {};
        for (int i = 0; i < n; i++)
            kb.push_back(byte'($urandom_range(1, 255)));
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.op <= OP_TAKE;
            req.key_chunk <= '0;
            req.chunk_last <= 1'b0;
            req.key_valid <= 1'b0;
            req.enabled <= 1'b0;
            req.slot <= '0;
            req.drop_untracked <= 1'b0;
            req.chunk_index <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                apply_transfer(cur_item);
                n_accepted++;
            end
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    req.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pend.size() > 0)
                begin
                    cur_item = pend.pop_front();
                    req.op <= cur_item.op;
                    req.key_chunk <= cur_item.key_chunk;
                    req.chunk_last <= cur_item.chunk_last;
                    req.key_valid <= cur_item.key_valid;
                    req.enabled <= cur_item.enabled;
                    req.slot <= cur_item.slot;
                    req.drop_untracked <= cur_item.drop_untracked;
                    req.chunk_index <= cur_item.chunk_index;
                    req.valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 3);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap <= 0;
            recv_hold <= 0;
            recv_cycles <= 0;
        end
        else
        begin
            recv_cycles <= recv_cycles + 1;
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: status %0d slot %0d count %0d data %h",
                                 rsp.status, rsp.slot_out, rsp.count, rsp.key_data);
                end
                else
                begin
                    rsp_item_t e;
                    e = awaited_results.pop_front();
                    if (rsp.status !== e.status || rsp.slot_out !== e.slot_out ||
                        rsp.count !== e.count || rsp.key_data !== e.key_data)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                                     e.status, e.slot_out, e.count, e.key_data,
                                     rsp.status, rsp.slot_out, rsp.count, rsp.key_data);
                    end
                end
            end
            if (recv_cycles == 4000)
            begin
                rsp.ready <= 1'b0;
                recv_hold <= 600;
            end
            else if (recv_hold > 0)
            begin
                rsp.ready <= 1'b0;
                recv_hold <= recv_hold - 1;
            end
            else if (recv_gap > 0)
            begin
                rsp.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    recv_gap <= $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc == LIMIT_CYCLES)
        begin
            $display("FAIL refcounted_endpoint_hash_table");
            $finish;
        end
    end

    initial
    begin
        byte unsigned kb[$];
        byte unsigned lib[$][$];
        int budget;
        int pick;
        int k;

        errors = 0;
        cyc = 0;
        n_queued = 0;
        n_accepted = 0;
        calm = 1'b0;
        reset_table();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        kb = {8'h61};
        queue_take(kb, 0, 0, 1, 1);
        queue_take(kb, 0, 0, 1, 1);
        make_key(8, kb);
        queue_take(kb, 1, 0, 1, 1);
        make_key(63, kb);
        queue_take(kb, 0, 0, 1, 1);
        make_key(64, kb);
        queue_take(kb, 1, 0, 1, 1);
        queue_simple(OP_CAPTURE, 10'd0, 0, 3'd0);
        queue_simple(OP_DROP, 10'd0, 1, 3'd0);
        queue_simple(OP_DROP, 10'd0, 1, 3'd0);
        make_key(5, kb);
        queue_take(kb, 0, 2, 0, 1);
        queue_simple(OP_DROP, 10'd0, 1, 3'd0);
        queue_take(kb, 0, 0, 1, 0);
        kb = {};
        queue_take(kb, 0, 0, 1, 1);
        repeat (6) queue_simple(OP_CAPTURE, 10'd0, 0, 3'd0);
        queue_simple(OP_DROP, 10'd1023, 0, 3'd0);
        queue_simple(OP_READ, 10'd1023, 0, 3'd0);
        queue_simple(OP_READ, 10'd1023, 0, 3'd7);
        queue_simple(OP_DROP, 10'd5, 0, 3'd0);
        queue_simple(OP_READ, 10'd1020, 0, 3'd7);

        // random
        for (int i = 0; i < 40; i++)
        begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 20);
            make_key(k, kb);
            lib.push_back(kb);
        end
        budget = 60;
        while (budget > 0)
        begin
            while (pend.size() > 8)
                @(posedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                kb = lib[$urandom_range(0, lib.size() - 1)];
                k = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
                queue_take(kb, $urandom_range(0, 3) == 0, k,
                           $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0);
                budget -= kb.size() / 8 + 1;
            end
            else if (pick < 72)
            begin
                if (taken_slots.size() > 0 && $urandom_range(0, 4) != 0)
                    queue_simple(OP_DROP, taken_slots[$urandom_range(0, taken_slots.size() - 1)],
                                 $urandom_range(0, 3) == 0, 3'($urandom));
                else
                    queue_simple(OP_DROP, 10'($urandom), $urandom_range(0, 2) == 0,
                                 3'($urandom));
                budget--;
            end
            else if (pick < 86 || written_slots.size() == 0)
            begin
                queue_simple(OP_CAPTURE, 10'($urandom), 1'($urandom), 3'($urandom));
                budget--;
            end
            else
            begin
                queue_simple(OP_READ, written_slots[$urandom_range(0, written_slots.size() - 1)],
                             1'($urandom), 3'($urandom));
                budget--;
            end
        end

        // fill the pool until it runs empty
        calm = 1'b1;
        for (int i = 0; i < 1030; i++)
        begin
            while (pend.size() > 8)
                @(posedge clk);
            kb = {8'hF1, byte'(1 + i % 255), byte'(1 + i / 255)};
            queue_take(kb, 0, 0, 1, 1);
        end
        for (int i = 0; i < 60; i++)
        begin
            while (pend.size() > 8)
                @(posedge clk);
            queue_simple(OP_DROP, 10'($urandom), 1, 3'($urandom));
        end
        for (int i = 0; i < 30; i++)
        begin
            while (pend.size() > 8)
                @(posedge clk);
            queue_simple(OP_CAPTURE, 10'($urandom), 0, 3'($urandom));
            if (i % 4 == 0)
                queue_simple(OP_DROP, taken_slots[$urandom_range(0, taken_slots.size() - 1)],
                             0, 3'($urandom));
            if (i % 5 == 0)
                queue_simple(OP_READ, written_slots[$urandom_range(0, written_slots.size() - 1)],
                             0, 3'($urandom));
        end

        wait (n_accepted == n_queued);
        wait (awaited_results.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("PASS refcounted_endpoint_hash_table");
        else
            $display("FAIL refcounted_endpoint_hash_table");
        $finish;
    end

endmodule
